>>> hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and codes of the page-frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W = 5;
	localparam int ADDR_W = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_W = 11;
	localparam int ACTIVE_RESET = 1024;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC,
		ST_FREE
	} state_t;

endpackage

>>> hw/rtl/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// Bitmap page-frame allocator: one bit per frame in a synchronous word memory.
// ----------------------------------------------------------------------------
// Sequence: a free item reads its word on the accepting edge, is checked in ST_FREE
// and raises done from a register; an allocate item scans in ST_ALLOC, one word per cycle.
// busy stays high until the item is finished, so a new item is taken only once the
// block is back in ST_IDLE.
// Reset: after arst_n a clearing pass writes MAP_WORDS zero words, busy high.
// Results are a one-cycle done strobe; the receiver cannot stall.
module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             command,
	input  logic [fba_pkg::ADDR_W-1:0]       frame_addr,
	input  logic                             active_frames_we,
	input  logic [fba_pkg::CFG_W-1:0]        active_frames,
	output logic                             done,
	output logic [fba_pkg::STATUS_W-1:0]     status,
	output logic [fba_pkg::ADDR_W-1:0]       alloc_addr
);

	localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
	localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int LIM_W = $clog2(MAX_FRAMES + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int LIMIT_RESET = (fba_pkg::ACTIVE_RESET > MAX_FRAMES) ?
		MAX_FRAMES : fba_pkg::ACTIVE_RESET;

	localparam int WORD_W = fba_pkg::WORD_W;
	localparam int BIT_W = fba_pkg::BIT_W;
	localparam int ADDR_W = fba_pkg::ADDR_W;

	fba_pkg::state_t state_q, state_d;

	logic [WORD_W-1:0] map_mem [MAP_WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic [WIDX_W-1:0] rd_idx;
	logic              wr_en;
	logic [WIDX_W-1:0] wr_idx;
	logic [WORD_W-1:0] wr_data;

	logic [LIM_W-1:0]  limit_q;
	logic [WIDX_W-1:0] word_idx_q, word_idx_d;
	logic [BIT_W-1:0]  bit_q, bit_d;
	logic              in_range_q, in_range_d;
	logic              done_q, done_d;
	logic [fba_pkg::STATUS_W-1:0] status_q, status_d;
	logic [ADDR_W-1:0] addr_q, addr_d;

	logic [ADDR_W-1:0] limit_ext;
	logic [ADDR_W-1:0] base_ext;
	logic [ADDR_W-1:0] remain;
	logic [WORD_W-1:0] valid_mask;
	logic [WORD_W-1:0] free_vec;
	logic [WORD_W-1:0] first_free;
	logic [BIT_W-1:0]  free_bit;
	logic              last_word;
	logic [ADDR_W-1:0] req_frame;
	logic              req_in_range;
	logic [WIDX_W+BIT_W-1:0] found_frame;
	logic [WORD_W-1:0] free_onehot;

	// Bitmap word memory, one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_idx] <= wr_data;
		end
		rd_data_q <= map_mem[rd_idx];
	end

	// Lowest free frame of the word on the read port that is below the limit.
	always_comb begin
		limit_ext = ADDR_W'(limit_q);
		base_ext = ADDR_W'({word_idx_q, {BIT_W{1'b0}}});
		remain = limit_ext - base_ext;
		last_word = (base_ext + ADDR_W'(WORD_W)) >= limit_ext;
		if (remain >= ADDR_W'(WORD_W)) begin
			valid_mask = '1;
		end else begin
			valid_mask = (WORD_W'(1) << remain[BIT_W-1:0]) - WORD_W'(1);
		end
		free_vec = ~rd_data_q & valid_mask;
		first_free = free_vec & (~free_vec + WORD_W'(1));
		free_bit = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (first_free[b]) begin
				free_bit = free_bit | BIT_W'(b);
			end
		end
		found_frame = {word_idx_q, free_bit};
		free_onehot = WORD_W'(1) << bit_q;
		req_frame = frame_addr >> PAGE_SHIFT;
		req_in_range = req_frame < limit_ext;
	end

	always_comb begin
		state_d = state_q;
		word_idx_d = word_idx_q;
		bit_d = bit_q;
		in_range_d = in_range_q;
		done_d = 1'b0;
		status_d = status_q;
		addr_d = addr_q;
		rd_idx = '0;
		wr_en = 1'b0;
		wr_idx = word_idx_q;
		wr_data = '0;
		case (state_q)
			fba_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				word_idx_d = word_idx_q + WIDX_W'(1);
				if (word_idx_q == WIDX_W'(MAP_WORDS - 1)) begin
					word_idx_d = '0;
					state_d = fba_pkg::ST_IDLE;
				end
			end
			fba_pkg::ST_IDLE: begin
				if (start) begin
					if (command == fba_pkg::CMD_ALLOC) begin
						word_idx_d = '0;
						state_d = fba_pkg::ST_ALLOC;
					end else begin
						// Out-of-range frames read word zero; the item fails anyway.
						if (req_in_range) begin
							rd_idx = req_frame[WIDX_W+BIT_W-1:BIT_W];
						end
						word_idx_d = rd_idx;
						bit_d = req_frame[BIT_W-1:0];
						in_range_d = req_in_range;
						state_d = fba_pkg::ST_FREE;
					end
				end
			end
			fba_pkg::ST_ALLOC: begin
				// The next word is read ahead while this one is examined.
				if (!last_word) begin
					rd_idx = word_idx_q + WIDX_W'(1);
				end
				if (first_free != '0) begin
					wr_en = 1'b1;
					wr_data = rd_data_q | first_free;
					done_d = 1'b1;
					status_d = fba_pkg::STATUS_OK;
					addr_d = ADDR_W'({ADDR_W'(found_frame), {PAGE_SHIFT{1'b0}}});
					state_d = fba_pkg::ST_IDLE;
				end else if (last_word) begin
					done_d = 1'b1;
					status_d = fba_pkg::STATUS_NO_FREE;
					addr_d = '0;
					state_d = fba_pkg::ST_IDLE;
				end else begin
					word_idx_d = word_idx_q + WIDX_W'(1);
				end
			end
			fba_pkg::ST_FREE: begin
				done_d = 1'b1;
				addr_d = '0;
				if (in_range_q && ((rd_data_q & free_onehot) != '0)) begin
					wr_en = 1'b1;
					wr_data = rd_data_q & ~free_onehot;
					status_d = fba_pkg::STATUS_OK;
				end else begin
					status_d = fba_pkg::STATUS_BAD_FREE;
				end
				state_d = fba_pkg::ST_IDLE;
			end
			default: begin
				state_d = fba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::ST_CLEAR;
			word_idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			word_idx_q <= word_idx_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		bit_q <= bit_d;
		in_range_q <= in_range_d;
		status_q <= status_d;
		addr_q <= addr_d;
	end

	// The frame count is clamped to the bitmap capacity when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(LIMIT_RESET);
		end else if (active_frames_we) begin
			if (32'(active_frames) > 32'(MAX_FRAMES)) begin
				limit_q <= LIM_W'(MAX_FRAMES);
			end else begin
				limit_q <= LIM_W'(active_frames);
			end
		end
	end

	assign busy = (state_q != fba_pkg::ST_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign alloc_addr = addr_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == fba_pkg::ST_ALLOC || $past(state_q) == fba_pkg::ST_FREE))
		else $error("done without an item in progress");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start work");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fba_pkg::STATUS_OK) |-> (alloc_addr == '0))
		else $error("failed item carries an address");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == fba_pkg::STATUS_OK || status == fba_pkg::STATUS_NO_FREE ||
			status == fba_pkg::STATUS_BAD_FREE))
		else $error("undefined status code");

endmodule
